[rtl/ttf_pkg.sv]
// ----------------------------------------------------------------------------
// ttf_pkg: shared types and helpers for the triangle tangent frame unit
// Item and result structs, the job passed from front to back, status codes
// and the fixed point helpers used by the front and the engine.
// ----------------------------------------------------------------------------
package ttf_pkg;

    // Input component handling: low COMPONENT_BITS of each 16-bit field
    localparam int COMPONENT_BITS = 16;
    localparam int SIGN_POS       = (COMPONENT_BITS > 16) ? 15 : COMPONENT_BITS - 1;
    localparam int CW             = 17;  // held component and difference width
    localparam int VW             = 40;  // working vector width in the back end
    localparam int FRAC_BITS      = 14;

    // Job queue geometry
    localparam int JQ_DEPTH = 2;
    localparam int JQ_AW    = 1;

    // Corner codes
    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DET_ZERO = 2'd1;
    localparam logic [1:0] ST_LEN_ZERO = 2'd2;

    typedef logic signed [CW-1:0] t_comp;
    typedef logic signed [VW-1:0] t_vec;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] tex_s;
        logic signed [15:0] tex_t;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [1:0]         corner;
    } t_in;

    typedef struct packed {
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_y;
        logic signed [15:0] tan_z;
        logic signed [15:0] bin_x;
        logic signed [15:0] bin_y;
        logic signed [15:0] bin_z;
        logic [1:0]         status;
    } t_out;

    // Edge and texture differences plus the normal of one triangle
    typedef struct packed {
        t_comp [2:0] d;
        t_comp [2:0] e;
        t_comp [1:0] f;
        t_comp [1:0] g;
        t_comp [2:0] n;
    } t_job;

    // Take the low component bits of a field as a two's complement number
    function automatic t_comp comp_of(input logic [15:0] f);
        t_comp v;
        v = t_comp'({1'b0, f});
        if (COMPONENT_BITS <= 16) begin
            for (int b = 0; b < CW; b++) begin
                if (b >= SIGN_POS) begin
                    v[b] = f[SIGN_POS];
                end
            end
        end
        return v;
    endfunction

    // Shift right by FRAC_BITS, rounding half away from zero
    function automatic logic signed [63:0] round_q14(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + 64'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

[rtl/ttf_front.sv]
// ----------------------------------------------------------------------------
// ttf_front: corner intake
// Holds corners A and B and the normal, and forms the triangle job
// (edge and texture differences) when corner C arrives.
// ----------------------------------------------------------------------------
module ttf_front (
    input  logic          i_clk,
    input  logic          i_accept,
    input  ttf_pkg::t_in  i_item,
    output logic          o_job_push,
    output ttf_pkg::t_job o_job
);
    import ttf_pkg::*;

    t_comp r_pos0 [3];
    t_comp r_pos1 [3];
    t_comp r_tex0 [2];
    t_comp r_tex1 [2];
    t_comp r_norm [3];
    t_comp w_pos  [3];
    t_comp w_tex  [2];
    t_comp w_norm [3];

    // Decode the incoming fields
    always_comb begin
        w_pos[0]  = comp_of(i_item.pos_x);
        w_pos[1]  = comp_of(i_item.pos_y);
        w_pos[2]  = comp_of(i_item.pos_z);
        w_tex[0]  = comp_of(i_item.tex_s);
        w_tex[1]  = comp_of(i_item.tex_t);
        w_norm[0] = comp_of(i_item.norm_x);
        w_norm[1] = comp_of(i_item.norm_y);
        w_norm[2] = comp_of(i_item.norm_z);
    end

    // Hold corners A and B
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            case (i_item.corner)
                CORNER_A: begin
                    r_pos0 <= w_pos;
                    r_tex0 <= w_tex;
                    r_norm <= w_norm;
                end
                CORNER_B: begin
                    r_pos1 <= w_pos;
                    r_tex1 <= w_tex;
                end
                default: begin
                end
            endcase
        end
    end

    // Form the job on corner C
    assign o_job_push = i_accept && (i_item.corner == CORNER_C);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_job.d[i] = r_pos1[i] - r_pos0[i];
            o_job.e[i] = w_pos[i] - r_pos0[i];
            o_job.n[i] = r_norm[i];
        end
        for (int i = 0; i < 2; i++) begin
            o_job.f[i] = r_tex1[i] - r_tex0[i];
            o_job.g[i] = w_tex[i] - r_tex0[i];
        end
    end

endmodule

[rtl/ttf_jobq.sv]
// ----------------------------------------------------------------------------
// ttf_jobq: job queue
// Short queue of triangle jobs between the intake and the solver.
// ----------------------------------------------------------------------------
module ttf_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttf_pkg::t_job i_data,
    input  logic          i_pop,
    output ttf_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);
    import ttf_pkg::*;

    t_job             r_mem [JQ_DEPTH];
    logic [JQ_AW-1:0] r_wp;
    logic [JQ_AW-1:0] r_rp;
    logic [JQ_AW:0]   r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == (JQ_AW+1)'(JQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/ttf_isqrt.sv]
// ----------------------------------------------------------------------------
// ttf_isqrt: integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module ttf_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_x;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic        r_busy;
    logic        r_done;
    logic [63:0] w_trial;
    logic        w_ge;

    assign w_trial = r_r + r_bit;
    assign w_ge    = (r_x >= w_trial);
    assign o_done  = r_done;
    assign o_root  = r_r[31:0];

    // Track the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Decide one root bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_r   <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            if (w_ge) begin
                r_x <= r_x - w_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

endmodule

[rtl/ttf_udiv.sv]
// ----------------------------------------------------------------------------
// ttf_udiv: unsigned divider
// Restoring division, 46-bit dividend by 33-bit divisor, 16 quotient bits,
// one bit per cycle. The dividend must be below divisor * 2^16.
// ----------------------------------------------------------------------------
module ttf_udiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [45:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quo
);
    logic [32:0] r_rem;
    logic [15:0] r_low;
    logic [15:0] r_q;
    logic [32:0] r_den;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_trial;
    logic        w_ge;
    logic [33:0] w_sub;

    assign w_trial = {r_rem, r_low[15]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_sub   = w_trial - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quo   = r_q;

    // Track the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 4'hF) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift in one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {3'b000, i_num[45:16]};
            r_low <= i_num[15:0];
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[32:0] : w_trial[32:0];
            r_low <= {r_low[14:0], 1'b0};
            r_q   <= {r_q[14:0], w_ge};
        end
    end

endmodule

[rtl/ttf_engine.sv]
// ----------------------------------------------------------------------------
// ttf_engine: tangent frame solver
// Sequencer over one shared multiplier: texture determinant, raw tangent
// and bitangent, rescale, projection, square root and per-component divide.
// Holds the finished result in an output register.
// ----------------------------------------------------------------------------
module ttf_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  ttf_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output ttf_pkg::t_out o_result
);
    import ttf_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DET   = 4'd1;
    localparam logic [3:0] S_TU    = 4'd2;
    localparam logic [3:0] S_FIT1  = 4'd3;
    localparam logic [3:0] S_DOTK  = 4'd4;
    localparam logic [3:0] S_DOTKT = 4'd5;
    localparam logic [3:0] S_SUBN  = 4'd6;
    localparam logic [3:0] S_SUBT  = 4'd7;
    localparam logic [3:0] S_ZCHK  = 4'd8;
    localparam logic [3:0] S_FIT2  = 4'd9;
    localparam logic [3:0] S_SQ    = 4'd10;
    localparam logic [3:0] S_SQRT  = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]         r_state;
    t_job               r_job;
    t_vec               r_v [3];
    t_vec               r_u [3];
    logic signed [15:0] r_tan [3];
    logic signed [15:0] r_bit [3];
    logic signed [63:0] r_acc;
    logic signed [63:0] r_prod;
    logic signed [34:0] r_k;
    logic signed [34:0] r_kt;
    logic [31:0]        r_s;
    logic [1:0]         r_idx;
    logic [1:0]         r_j;
    logic               r_ph;
    logic               r_neg;
    logic               r_second;
    logic [1:0]         r_status;
    logic               r_out_valid;
    t_out               r_out;

    logic signed [34:0] m_a;
    logic signed [30:0] m_b;
    logic signed [65:0] w_prod;
    logic signed [63:0] w_diff;
    logic signed [63:0] w_tu;
    logic signed [63:0] w_dsum;
    logic signed [63:0] w_kround;
    logic signed [63:0] w_rprod;
    logic [VW-1:0]      w_abs [3];
    t_vec               w_half [3];
    logic [VW-1:0]      w_mag;
    logic               w_zero;
    logic               w_big;
    logic               w_small;
    logic [VW-1:0]      w_av;
    logic               sq_start;
    logic               sq_done;
    logic [31:0]        sq_root;
    logic               dv_start;
    logic               dv_done;
    logic [15:0]        dv_q;
    logic signed [15:0] w_comp;
    logic               w_ok;

    // Pick multiplier operands for the current step
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_DET: begin
                if (r_j == 2'd0) begin
                    m_a = 35'($signed(r_job.f[0]));
                    m_b = 31'($signed(r_job.g[1]));
                end else begin
                    m_a = 35'($signed(r_job.f[1]));
                    m_b = 31'($signed(r_job.g[0]));
                end
            end
            S_TU: begin
                case (r_j)
                    2'd0: begin
                        m_a = 35'($signed(r_job.g[1]));
                        m_b = 31'($signed(r_job.d[r_idx]));
                    end
                    2'd1: begin
                        m_a = 35'($signed(r_job.f[1]));
                        m_b = 31'($signed(r_job.e[r_idx]));
                    end
                    2'd2: begin
                        m_a = 35'($signed(r_job.f[0]));
                        m_b = 31'($signed(r_job.e[r_idx]));
                    end
                    default: begin
                        m_a = 35'($signed(r_job.g[0]));
                        m_b = 31'($signed(r_job.d[r_idx]));
                    end
                endcase
            end
            S_DOTK: begin
                m_a = r_v[r_idx][34:0];
                m_b = 31'($signed(r_job.n[r_idx]));
            end
            S_DOTKT: begin
                m_a = r_v[r_idx][34:0];
                m_b = 31'(r_tan[r_idx]);
            end
            S_SUBN: begin
                m_a = r_k;
                m_b = 31'($signed(r_job.n[r_idx]));
            end
            S_SUBT: begin
                m_a = r_kt;
                m_b = 31'(r_tan[r_idx]);
            end
            S_SQ: begin
                m_a = r_v[r_idx][34:0];
                m_b = r_v[r_idx][30:0];
            end
            default: begin
            end
        endcase
    end

    assign w_prod   = m_a * m_b;
    assign w_diff   = r_acc - r_prod;
    assign w_tu     = r_neg ? -w_diff : w_diff;
    assign w_dsum   = (r_idx == 2'd0) ? r_prod : r_acc + r_prod;
    assign w_kround = round_q14(w_dsum);
    assign w_rprod  = round_q14(r_prod);

    // Magnitude scan for the power of two rescale
    always_comb begin
        w_mag = '0;
        for (int i = 0; i < 3; i++) begin
            w_abs[i]  = r_v[i][VW-1] ? VW'(-r_v[i]) : VW'(r_v[i]);
            w_half[i] = $signed(r_v[i] + {{(VW-1){1'b0}}, r_v[i][VW-1]}) >>> 1;
            if (w_abs[i] > w_mag) begin
                w_mag = w_abs[i];
            end
        end
    end

    assign w_zero  = (w_mag == '0);
    assign w_big   = |w_mag[VW-1:30];
    assign w_small = ~|w_mag[VW-1:29];

    // Square root and divide units
    assign sq_start = (r_state == S_SQRT) && !r_ph;
    assign dv_start = (r_state == S_DIV) && !r_ph;
    assign w_av     = r_v[r_idx][VW-1] ? VW'(-r_v[r_idx]) : VW'(r_v[r_idx]);
    assign w_comp   = r_v[r_idx][VW-1] ? -$signed(dv_q) : $signed(dv_q);

    ttf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (r_acc),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    ttf_udiv u_udiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (46'({w_av[29:0], 15'd0}) + 46'(r_s)),
        .i_den   ({1'b0, r_s} << 1),
        .o_done  (dv_done),
        .o_quo   (dv_q)
    );

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;
    assign w_ok      = (r_status == ST_OK);

    // Step the sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ph        <= 1'b0;
            r_idx       <= '0;
            r_j         <= '0;
            r_second    <= 1'b0;
        end else begin
            r_prod <= w_prod[63:0];
            // Drop the popped beat unless a new result replaces it below
            if (i_pop && r_out_valid && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job    <= i_job;
                        r_second <= 1'b0;
                        r_idx    <= '0;
                        r_j      <= '0;
                        r_ph     <= 1'b0;
                        r_status <= ST_OK;
                        r_state  <= S_DET;
                    end
                end
                S_DET: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        if (r_j == 2'd0) begin
                            r_acc <= r_prod;
                            r_j   <= 2'd1;
                        end else begin
                            r_j   <= 2'd0;
                            r_neg <= w_diff[63];
                            if (w_diff == '0) begin
                                r_status <= ST_DET_ZERO;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_TU;
                            end
                        end
                    end
                end
                S_TU: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        case (r_j)
                            2'd0:    r_acc <= r_prod;
                            2'd1:    r_v[r_idx] <= w_tu[VW-1:0];
                            2'd2:    r_acc <= r_prod;
                            default: r_u[r_idx] <= w_tu[VW-1:0];
                        endcase
                        r_j <= r_j + 1'b1;
                        if (r_j == 2'd3) begin
                            if (r_idx == 2'd2) begin
                                r_idx   <= '0;
                                r_state <= S_FIT1;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end
                end
                S_FIT1, S_FIT2: begin
                    if (w_zero || (!w_big && !w_small)) begin
                        r_idx   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= (r_state == S_FIT1) ? S_DOTK : S_SQ;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            r_v[i] <= w_big ? w_half[i] : (r_v[i] <<< 1);
                        end
                    end
                end
                S_DOTK, S_DOTKT, S_SQ: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_acc <= w_dsum;
                        if (r_idx == 2'd2) begin
                            r_idx <= '0;
                            case (r_state)
                                S_DOTK: begin
                                    r_k     <= w_kround[34:0];
                                    r_state <= r_second ? S_DOTKT : S_SUBN;
                                end
                                S_DOTKT: begin
                                    r_kt    <= w_kround[34:0];
                                    r_state <= S_SUBN;
                                end
                                default: r_state <= S_SQRT;
                            endcase
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_SUBN, S_SUBT: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_v[r_idx] <= r_v[r_idx] - w_rprod[VW-1:0];
                        if (r_idx == 2'd2) begin
                            r_idx <= '0;
                            if (r_state == S_SUBN && r_second) begin
                                r_state <= S_SUBT;
                            end else begin
                                r_state <= S_ZCHK;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_ZCHK: begin
                    if (w_zero) begin
                        r_status <= ST_LEN_ZERO;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_FIT2;
                    end
                end
                S_SQRT: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (sq_done) begin
                        r_s     <= sq_root;
                        r_ph    <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (dv_done) begin
                        r_ph <= 1'b0;
                        if (r_second) begin
                            r_bit[r_idx] <= w_comp;
                        end else begin
                            r_tan[r_idx] <= w_comp;
                        end
                        if (r_idx == 2'd2) begin
                            r_idx <= '0;
                            if (r_second) begin
                                r_state <= S_OUT;
                            end else begin
                                r_second <= 1'b1;
                                r_v      <= r_u;
                                r_state  <= S_FIT1;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_pop) begin
                        r_out.tan_x  <= w_ok ? r_tan[0] : '0;
                        r_out.tan_y  <= w_ok ? r_tan[1] : '0;
                        r_out.tan_z  <= w_ok ? r_tan[2] : '0;
                        r_out.bin_x  <= w_ok ? r_bit[0] : '0;
                        r_out.bin_y  <= w_ok ? r_bit[1] : '0;
                        r_out.bin_z  <= w_ok ? r_bit[2] : '0;
                        r_out.status <= r_status;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/triangle_tangent_frame_unit.sv]
// ----------------------------------------------------------------------------
// triangle_tangent_frame_unit: tangent and bitangent of a textured triangle
// Corners A and B are held in the intake; corner C queues a triangle job that
// the solver works through, with power of two rescaling where needed at four
// points; a zero determinant ends the job early. The solver takes one job at a
// time, paced by the shared multiplier and the bit-serial square root and
// divider; a two-job queue absorbs new corners. Reset empties the job queue
// and the result register; held corners stay undefined until written.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  ttf_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output ttf_pkg::t_out o_result
);
    import ttf_pkg::*;

    logic w_accept;
    logic w_job_push;
    t_job w_job_in;
    t_job w_job_out;
    logic w_job_empty;
    logic w_job_pop;

    assign w_accept = push && !full;

    // Corner intake
    ttf_front u_front (
        .i_clk      (i_clk),
        .i_accept   (w_accept),
        .i_item     (i_item),
        .o_job_push (w_job_push),
        .o_job      (w_job_in)
    );

    // Job queue between intake and solver
    ttf_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_full  (full),
        .o_empty (w_job_empty)
    );

    // Solver with result register
    ttf_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule
